/* sv/lua_pkg.sv */
// Shared constants, codes and handshake structs of the least-used ID allocator.
`default_nettype none
package lua_pkg;

    localparam int NUM_IDS    = 256;
    localparam int COUNT_BITS = 8;
    localparam int ID_W       = 8;
    localparam int ADDR_W     = $clog2(NUM_IDS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_FIELD_W  = 1 + ID_W + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    // highest ID that has storage behind it
    localparam logic [ID_W-1:0] LAST_ID =
        (NUM_IDS > (1 << ID_W)) ? '1 : ID_W'(NUM_IDS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ID      = 2'd0,
        REG_MAX_ID      = 2'd1,
        REG_STRICT      = 2'd2,
        REG_NEVER_REUSE = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_ALLOC_WR,
        ST_RET_RD,
        ST_RET_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_scan;
        logic rd_ret;
        logic alloc_wr;
        logic ret_wr;
        logic out_load;
    } lua_cmd_t;

    typedef struct packed {
        logic in_ret;
        logic range_empty;
        logic ret_skip;
        logic scan_last;
        logic out_free;
    } lua_status_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

endpackage
`default_nettype wire

/* sv/lua_ctrl.sv */
// Sequencing state machine of the allocator.
`default_nettype none
module lua_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  lua_pkg::lua_status_t st,
    output lua_pkg::lua_cmd_t    cmd
);
    import lua_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (st.in_ret)
                    begin
                        state_next = st.ret_skip ? ST_FINISH : ST_RET_RD;
                    end
                    else
                    begin
                        state_next = st.range_empty ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_ALLOC_WR;
            ST_ALLOC_WR: state_next = ST_FINISH;
            ST_RET_RD:   state_next = ST_RET_WR;
            ST_RET_WR:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SCAN:     cmd.rd_scan  = 1'b1;
            ST_SCAN_END: ;
            ST_ALLOC_WR: cmd.alloc_wr = 1'b1;
            ST_RET_RD:   cmd.rd_ret   = 1'b1;
            ST_RET_WR:   cmd.ret_wr   = 1'b1;
            ST_FINISH:   cmd.out_load = st.out_free;
            default:     ;
        endcase
    end

endmodule
`default_nettype wire

/* sv/lua_dp.sv */
// Datapath: config registers, count memory, min-count scan and output register.
`default_nettype none
module lua_dp (
    input  wire                             clk,
    input  wire                             rst_n,
    input  lua_pkg::lua_cmd_t               cmd,
    output lua_pkg::lua_status_t            st,
    input  wire  [lua_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [lua_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire                             cfg_valid,
    input  wire  [lua_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [lua_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lua_pkg::*;

    logic [ID_W-1:0]       min_id_reg;
    logic [ID_W-1:0]       max_id_reg;
    logic                  strict_reg;
    logic                  never_reuse_reg;

    logic [COUNT_BITS-1:0] mem [NUM_IDS];
    logic [NUM_IDS-1:0]    valid_reg;

    logic [ID_W-1:0]       addr_reg;
    logic [ID_W-1:0]       rd_id_reg;
    logic [ID_W-1:0]       rid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic                  cmp_vld_reg;
    logic                  found_reg;
    logic [ID_W-1:0]       best_id_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  res_granted_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic                  res_oor_reg;
    logic                  m_valid_reg;
    logic [M_FIELD_W-1:0]  m_fields_reg;

    logic [ID_W-1:0]       top;
    logic [ID_W-1:0]       in_rid;
    logic                  in_oor;
    logic [COUNT_BITS-1:0] cand;
    logic                  grant;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic                  rd_en;

    assign top    = (max_id_reg > LAST_ID) ? LAST_ID : max_id_reg;
    assign in_rid = s_tdata[ID_W-1:0];
    assign in_oor = (in_rid < min_id_reg) || (in_rid > top);
    assign cand   = rd_vld_reg ? rd_data_reg : '0;
    assign grant  = !(strict_reg && (best_cnt_reg != '0));
    assign rd_en  = cmd.rd_scan || cmd.rd_ret;

    assign st.in_ret      = s_tuser;
    assign st.range_empty = min_id_reg > top;
    assign st.ret_skip    = never_reuse_reg || in_oor;
    assign st.scan_last   = addr_reg == top;
    assign st.out_free    = !m_valid_reg || m_tready;

    // write port: saturating increment on grant, flooring decrement on return
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = to_addr(best_id_reg);
        mem_wd = (best_cnt_reg == COUNT_MAX) ? COUNT_MAX : best_cnt_reg + 1'b1;
        if (cmd.alloc_wr)
        begin
            mem_we = grant;
        end
        else if (cmd.ret_wr)
        begin
            mem_we = 1'b1;
            mem_wa = to_addr(rid_reg);
            mem_wd = (cand == '0) ? '0 : cand - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[to_addr(addr_reg)];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_id_reg      <= ID_W'(1);
            max_id_reg      <= ID_W'(255);
            strict_reg      <= 1'b0;
            never_reuse_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_ID:      min_id_reg      <= cfg_data[ID_W-1:0];
                REG_MAX_ID:      max_id_reg      <= cfg_data[ID_W-1:0];
                REG_STRICT:      strict_reg      <= cfg_data[0];
                REG_NEVER_REUSE: never_reuse_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            rd_vld_reg  <= valid_reg[to_addr(addr_reg)];
            cmp_vld_reg <= cmd.rd_scan;
            if (cmd.accept)
            begin
                found_reg <= 1'b0;
            end
            else if (cmp_vld_reg && (!found_reg || cand < best_cnt_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg        <= s_tuser ? in_rid : min_id_reg;
            rid_reg         <= in_rid;
            res_granted_reg <= 1'b0;
            res_id_reg      <= '0;
            res_oor_reg     <= s_tuser && !never_reuse_reg && in_oor;
        end
        else if (rd_en)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_id_reg <= addr_reg;
        end
        if (cmp_vld_reg && (!found_reg || cand < best_cnt_reg))
        begin
            best_id_reg  <= rd_id_reg;
            best_cnt_reg <= cand;
        end
        if (cmd.alloc_wr)
        begin
            res_granted_reg <= grant;
            res_id_reg      <= grant ? best_id_reg : '0;
        end
        if (cmd.out_load)
        begin
            m_fields_reg <= {res_oor_reg, res_id_reg, res_granted_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_fields_reg);

endmodule
`default_nettype wire

/* sv/least_used_id_allocator_top.sv */
// Top level of the least-used ID allocator: controller plus datapath.
//
// Usage:
//   s_* channel: one request per transfer. s_tuser is the mode (0 allocate,
//     1 return); s_tdata[7:0] is the ID being returned (ignored on allocate).
//   m_* channel: one result per request, in order. m_tdata bit 0 granted,
//     bits 8:1 grant_id (0 when nothing granted), bit 9 out_of_range,
//     bits 15:10 zero.
//   cfg_* channel: register writes, always ready. Index 0 min_id, 1 max_id,
//     2 strict_unique (bit 0), 3 never_reuse (bit 0). Write only while idle.
// Timing:
//   Allocate walks the count memory one ID per cycle over min_id..max_id,
//   then writes the winner's count back and loads the result. A return
//   reads the count, writes it back and loads the output. Skipped returns
//   and empty-range allocates go straight to the output step.
//   One request is in flight at a time; the single-port read of the count
//   memory sets the scan rate.
// Reset: all counts read as zero (per-ID valid bits cleared), config
//   registers return to min_id 1, max_id 255, both modes off.
// Stall: a result waits in the output register while m_tready is low; the
//   next request is still taken and worked, and holds in its last step
//   until the output register frees.
`default_nettype none
module least_used_id_allocator_top (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [lua_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] ret_id
    input  wire                             s_tuser,   // [0] mode
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [lua_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] granted, [8:1] grant_id,
                                                       // [9] out_of_range, [15:10] zero
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [lua_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [lua_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lua_pkg::*;

    lua_cmd_t    cmd;
    lua_status_t st;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    lua_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lua_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

/* sv/lua_checker.sv */
// Port-level checker of the allocator and its bind to the top level.
`default_nettype none
module lua_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    // the output flop is cleared asynchronously by reset; check valid after each edge seen in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("grant_id nonzero without grant");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]) && m_tdata[15:10] == 6'd0)
        else $error("grant and out_of_range together, or pad bits set");

endmodule

bind least_used_id_allocator_top lua_checker u_lua_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the least-used ID allocator: directed and random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lua_pkg::*;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RETURN  = 1'b1;
    localparam int   GAP_MAX      = 12;
    localparam int   MAX_REPORTS  = 10;
    // wait a while longer for stray results
    localparam int   DRAIN_CYCLES = 300;
    localparam int   HELD_CAP     = 1024;

    // one result transfer, split into its fields
    typedef struct packed {
        logic            granted;
        logic [ID_W-1:0] grant_id;
        logic            out_of_range;
    } grant_t;

    // Tracks per-ID holder counts and the results still owed by the block.
    class grant_tracker;
        logic [ID_W-1:0]       min_id;
        logic [ID_W-1:0]       max_id;
        logic                  strict_unique;
        logic                  never_reuse;
        logic [COUNT_BITS-1:0] holders [NUM_IDS];
        grant_t                grants_due [$];
        int                    held_ids [$];
        int                    mismatches;

        function new();
            min_id        = 8'd1;
            max_id        = 8'd255;
            strict_unique = 1'b0;
            never_reuse   = 1'b0;
            foreach (holders[i])
                holders[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MIN_ID:      min_id        = value[ID_W-1:0];
                REG_MAX_ID:      max_id        = value[ID_W-1:0];
                REG_STRICT:      strict_unique = value[0];
                REG_NEVER_REUSE: never_reuse   = value[0];
                default: ;
            endcase
        endfunction

        function bit log_error();
            mismatches++;
            return mismatches <= MAX_REPORTS;
        endfunction

        // work out the result of one accepted request and update the counts
        function void take_request(logic mode, logic [ID_W-1:0] rid);
            grant_t res;
            int     top;
            int     best;
            int     best_cnt;
            bit     found;
            res      = '0;
            top      = (int'(max_id) > NUM_IDS - 1) ? NUM_IDS - 1 : int'(max_id);
            found    = 1'b0;
            best     = 0;
            best_cnt = 0;
            if (mode == MODE_ALLOC)
            begin
                // lowest count wins, lowest ID on ties
                for (int i = int'(min_id); i <= top; i++)
                begin
                    if (!found || int'(holders[i]) < best_cnt)
                    begin
                        found    = 1'b1;
                        best     = i;
                        best_cnt = int'(holders[i]);
                    end
                end
                if (found && !(strict_unique && best_cnt != 0))
                begin
                    if (holders[best] != COUNT_MAX)
                        holders[best] = holders[best] + 1'b1;
                    res.granted  = 1'b1;
                    res.grant_id = ID_W'(best);
                    held_ids.push_back(best);
                    if (held_ids.size() > HELD_CAP)
                        void'(held_ids.pop_front());
                end
            end
            else if (!never_reuse)
            begin
                if (int'(rid) < int'(min_id) || int'(rid) > top)
                    res.out_of_range = 1'b1;
                else if (holders[rid] != '0)
                    holders[rid] = holders[rid] - 1'b1;
            end
            grants_due.push_back(res);
        endfunction

        function void check_grant(logic [M_TDATA_W-1:0] data);
            grant_t got;
            grant_t want;
            got.granted      = data[0];
            got.grant_id     = data[ID_W:1];
            got.out_of_range = data[ID_W+1];
            if (grants_due.size() == 0)
            begin
                if (log_error())
                    $display("%0t: result with nothing pending: granted=%0d id=%0d oor=%0d",
                             $realtime, got.granted, got.grant_id, got.out_of_range);
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted || got.grant_id !== want.grant_id ||
                got.out_of_range !== want.out_of_range)
            begin
                if (log_error())
                    $display("%0t: result mismatch: exp granted=%0d id=%0d oor=%0d, got granted=%0d id=%0d oor=%0d",
                             $realtime, want.granted, want.grant_id, want.out_of_range,
                             got.granted, got.grant_id, got.out_of_range);
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    grant_tracker tracker;

    // stall-free stretches left on each side
    int send_run = 0;
    int recv_run = 0;

    least_used_id_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] ret_id
        .s_tuser   (s_tuser),    // [0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [0] granted, [8:1] grant_id, [9] out_of_range
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle cycles before the next transfer; now and then a stretch with none
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // mostly return IDs that were handed out, else something in or out of range
    function automatic logic [ID_W-1:0] pick_return_id(int lo, int hi);
        int k;
        int sel;
        int id;
        k = $urandom_range(0, 99);
        if (k < 50 && tracker.held_ids.size() > 0)
        begin
            sel = $urandom_range(0, tracker.held_ids.size() - 1);
            id  = tracker.held_ids[sel];
            tracker.held_ids.delete(sel);
            return ID_W'(id);
        end
        if (k < 80 && lo <= hi)
            return ID_W'($urandom_range(lo, hi));
        return ID_W'($urandom_range(0, 255));
    endfunction

    // one request transfer; valid stays up when the next one follows at once
    task automatic send_request(logic mode, logic [ID_W-1:0] rid);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= rid;
        do @(posedge clk); while (!s_tready);
        tracker.take_request(mode, rid);
    endtask

    // stop sending and wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.grants_due.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    // registers change only with the block idle
    task automatic set_config(int lo, int hi, bit strict, bit no_reuse);
        wait_drained();
        write_reg(REG_MIN_ID, CFG_DATA_W'(lo));
        write_reg(REG_MAX_ID, CFG_DATA_W'(hi));
        write_reg(REG_STRICT, CFG_DATA_W'(strict));
        write_reg(REG_NEVER_REUSE, CFG_DATA_W'(no_reuse));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int lo, int hi, bit strict, bit no_reuse, int count,
                             int alloc_pct);
        set_config(lo, hi, strict, no_reuse);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(MODE_ALLOC, ID_W'($urandom_range(0, 255)));
            else
                send_request(MODE_RETURN, pick_return_id(lo, hi));
        end
    endtask

    // result side: random backpressure, one transfer per draw
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_run);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // every result transfer goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_grant(m_tdata);
    end

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: range 1..255, both modes off
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'hFF);
        send_request(MODE_RETURN, 8'd1);
        send_request(MODE_RETURN, 8'd0);     // below range
        send_request(MODE_RETURN, 8'd255);   // free ID, count stays zero
        send_request(MODE_RETURN, 8'd1);     // already free
        send_request(MODE_ALLOC, 8'h5A);

        set_config(0, 255, 1'b0, 1'b0);
        send_request(MODE_ALLOC, 8'hA5);     // ID 0 now eligible

        // single ID, strict: second allocate must fail
        set_config(5, 5, 1'b1, 1'b0);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_RETURN, 8'd5);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_RETURN, 8'd6);     // above range

        // never-reuse: returns ignored, even out of range
        set_config(5, 5, 1'b1, 1'b1);
        send_request(MODE_RETURN, 8'd5);
        send_request(MODE_RETURN, 8'd200);
        send_request(MODE_ALLOC, 8'h00);

        // empty range
        set_config(10, 9, 1'b0, 1'b0);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_RETURN, 8'd9);
        send_request(MODE_RETURN, 8'd10);

        // top of the ID space
        set_config(255, 255, 1'b0, 1'b0);
        send_request(MODE_ALLOC, 8'hFF);
        send_request(MODE_RETURN, 8'd255);
        send_request(MODE_ALLOC, 8'h00);

        // random phases; the single-ID never-reuse run drives its count to saturation
        run_phase(0, 255, 1'b0, 1'b0, 150, 60);
        run_phase(0, 7, 1'b1, 1'b0, 200, 55);
        run_phase(200, 255, 1'b0, 1'b0, 150, 60);
        run_phase(3, 3, 1'b0, 1'b1, 300, 95);
        run_phase(3, 3, 1'b0, 1'b0, 100, 30);
        run_phase(250, 10, 1'b0, 1'b0, 40, 50);
        run_phase(255, 255, 1'b1, 1'b0, 60, 50);
        run_phase(16, 47, 1'b0, 1'b0, 100, 55);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard: ends the run if it never finishes
    initial
    begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* least_used_id_allocator_top.f */
sv/lua_pkg.sv
sv/lua_ctrl.sv
sv/lua_dp.sv
sv/least_used_id_allocator_top.sv
sv/lua_checker.sv
sim/tb_top.sv
